### rtl/core/gf16mr_pkg.sv
// Package for the GF(2^16) matrix round layer: types, matrices and field helpers.
package gf16mr_pkg;

	localparam int WORDS  = 8;
	localparam int WORD_W = 16;
	localparam int RND_W  = 3;

	// low part of x^16 + x^5 + x^3 + x + 1
	localparam logic [WORD_W-1:0] POLY_LOW = 16'h002B;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RND_W-1:0] rnd_t;
	typedef word_t [WORDS-1:0] vec_t;
	typedef word_t [0:WORDS-1][0:WORDS-1] mat_t;
	typedef word_t [0:WORDS-1][0:WORD_W-1] basis_t;

	typedef enum logic {
		KIND_FWD = 1'b0,
		KIND_INV = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t kind;
		rnd_t  round_index;
		word_t word_0;
		word_t word_1;
		word_t word_2;
		word_t word_3;
		word_t word_4;
		word_t word_5;
		word_t word_6;
		word_t word_7;
	} req_t;

	typedef struct packed {
		word_t out_0;
		word_t out_1;
		word_t out_2;
		word_t out_3;
		word_t out_4;
		word_t out_5;
		word_t out_6;
		word_t out_7;
	} rsp_t;

	// what one cell hands to the next
	typedef struct packed {
		logic  valid;
		kind_t kind;
		rnd_t  rnd;
		vec_t  x;
		vec_t  acc;
	} stage_t;

	localparam mat_t FWD_MAT = '{
		'{16'h1967, 16'h2BA9, 16'h659C, 16'h7CFB, 16'h5752, 16'hCB38, 16'hE091, 16'h4E35},
		'{16'hB1C3, 16'h6F41, 16'hD26E, 16'hBD2F, 16'h7A75, 16'h63AD, 16'h0CEC, 16'hCBB6},
		'{16'h64CE, 16'hFDE8, 16'h9926, 16'hAB41, 16'h62DD, 16'hCF8F, 16'h56A9, 16'hC99C},
		'{16'h40E8, 16'h00D7, 16'hC041, 16'h403F, 16'hC096, 16'hC1EF, 16'h01AE, 16'h80A9},
		'{16'hAC87, 16'h91DF, 16'h4789, 16'h1EAC, 16'hB22B, 16'hD656, 16'hC8FA, 16'h7AD1},
		'{16'hC9BC, 16'h56B1, 16'hCF93, 16'h62F1, 16'hAB4D, 16'h9922, 16'hFDFC, 16'h64DE},
		'{16'h1472, 16'h7D59, 16'hB480, 16'h4E32, 16'h2719, 16'hEEC0, 16'hC9D9, 16'h5A40},
		'{16'hD081, 16'h271E, 16'h5AF3, 16'hFBDA, 16'h8637, 16'hAD6C, 16'h7DED, 16'h2B5B}
	};

	localparam mat_t INV_MAT = '{
		'{16'h8644, 16'h738D, 16'h42A7, 16'h86B1, 16'h9477, 16'h07D8, 16'h9B6A, 16'hB308},
		'{16'h8AE7, 16'hD162, 16'h1204, 16'h077A, 16'h3086, 16'h021A, 16'hF967, 16'h19FC},
		'{16'h1946, 16'h9497, 16'h50A3, 16'h8276, 16'hFAA8, 16'h02E1, 16'hB113, 16'h3341},
		'{16'h9F02, 16'h45F5, 16'hF1E5, 16'h81CB, 16'hD26D, 16'h06D5, 16'h43F6, 16'h557A},
		'{16'h15E5, 16'h8BEA, 16'h74AB, 16'h850C, 16'h461A, 16'h010D, 16'h21FB, 16'h7FC7},
		'{16'h328C, 16'hE71A, 16'hB342, 16'h8C82, 16'hCA2E, 16'h00FB, 16'h698F, 16'h99B5},
		'{16'hB86B, 16'h3678, 16'hE3E1, 16'h0EF4, 16'h1843, 16'h0317, 16'h4874, 16'h2ABD},
		'{16'h93A1, 16'hF867, 16'h854E, 16'h04C7, 16'h5E59, 16'h03EC, 16'hD89C, 16'hE672}
	};

	// Column b of a matrix as basis vectors: entry [s][i] = mat[s][b] * x^i mod p.
	// Only evaluated on constants, at elaboration.
	function automatic basis_t col_basis(mat_t mat, int b);
		basis_t res;
		word_t  m;
		for (int s = 0; s < WORDS; s++) begin
			m = mat[s][b];
			for (int i = 0; i < WORD_W; i++) begin
				res[s][i] = m;
				m = m[WORD_W-1] ? ({m[WORD_W-2:0], 1'b0} ^ POLY_LOW) : {m[WORD_W-2:0], 1'b0};
			end
		end
		return res;
	endfunction

	// round constant 8*rnd + s + 1
	function automatic word_t round_const(rnd_t rnd, int s);
		logic [RND_W+3:0] v;
		v = {1'b0, rnd, 3'(s)} + (RND_W+4)'(1);
		return {(WORD_W-RND_W-4)'(0), v};
	endfunction

endpackage

### rtl/core/gf16mr_cell.sv
// One cell of the chain: folds word CELL times its matrix column into all eight sums.
module gf16mr_cell #(
	parameter int CELL = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  gf16mr_pkg::stage_t  prev,
	output gf16mr_pkg::stage_t  next
);

	localparam gf16mr_pkg::basis_t FWD_B = gf16mr_pkg::col_basis(gf16mr_pkg::FWD_MAT, CELL);
	localparam gf16mr_pkg::basis_t INV_B = gf16mr_pkg::col_basis(gf16mr_pkg::INV_MAT, CELL);

	gf16mr_pkg::vec_t    acc_d;
	gf16mr_pkg::word_t   xb;
	logic                valid_q;
	gf16mr_pkg::kind_t   kind_q;
	gf16mr_pkg::rnd_t    rnd_q;
	gf16mr_pkg::vec_t    x_q;
	gf16mr_pkg::vec_t    acc_q;

	assign xb = prev.x[CELL];

	// constant multiply is a linear map: XOR of basis rows picked by the bits of xb
	always_comb begin
		for (int s = 0; s < gf16mr_pkg::WORDS; s++) begin
			acc_d[s] = prev.acc[s];
			for (int i = 0; i < gf16mr_pkg::WORD_W; i++) begin
				if (xb[i]) begin
					acc_d[s] = acc_d[s] ^
						((prev.kind == gf16mr_pkg::KIND_INV) ? INV_B[s][i] : FWD_B[s][i]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_q <= prev.kind;
			rnd_q  <= prev.rnd;
			x_q    <= prev.x;
			acc_q  <= acc_d;
		end
	end

	assign next = {valid_q, kind_q, rnd_q, x_q, acc_q};

endmodule

### rtl/core/gf16_matrix_round_layer.sv
// Top level: eight-cell chain computing one GF(2^16) matrix round layer per item.
// Path: an accepted item passes through the 8 cell registers, then the 1 output register, before rsp_valid rises.
// Throughput: one item per cycle while not stalled; the cell chain moves one cell per enabled cycle.
// The whole chain stalls together while a result waits on rsp_ready.
// Reset (arst_n low, asynchronous) empties the chain and the output register;
// data registers are not reset.
module gf16_matrix_round_layer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  gf16mr_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output gf16mr_pkg::rsp_t   rsp
);

	localparam int N = gf16mr_pkg::WORDS;

	logic                en;
	gf16mr_pkg::vec_t    xin;
	gf16mr_pkg::stage_t  head;
	gf16mr_pkg::stage_t  chain [N+1];
	gf16mr_pkg::vec_t    fin;
	logic                rsp_valid_q;
	gf16mr_pkg::rsp_t    rsp_q;

	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;

	assign xin[0] = req.word_0;
	assign xin[1] = req.word_1;
	assign xin[2] = req.word_2;
	assign xin[3] = req.word_3;
	assign xin[4] = req.word_4;
	assign xin[5] = req.word_5;
	assign xin[6] = req.word_6;
	assign xin[7] = req.word_7;

	// inverse direction adds the round constant before the matrix
	always_comb begin
		head.valid = req_valid;
		head.kind  = req.kind;
		head.rnd   = req.round_index;
		head.acc   = '0;
		for (int s = 0; s < N; s++) begin
			head.x[s] = (req.kind == gf16mr_pkg::KIND_INV) ?
				(xin[s] ^ gf16mr_pkg::round_const(req.round_index, s)) : xin[s];
		end
	end

	assign chain[0] = head;

	for (genvar b = 0; b < N; b++) begin : g_cell
		gf16mr_cell #(
			.CELL(b)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.prev   (chain[b]),
			.next   (chain[b+1])
		);
	end

	// forward direction adds the round constant after the matrix
	always_comb begin
		for (int s = 0; s < N; s++) begin
			fin[s] = (chain[N].kind == gf16mr_pkg::KIND_FWD) ?
				(chain[N].acc[s] ^ gf16mr_pkg::round_const(chain[N].rnd, s)) : chain[N].acc[s];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= chain[N].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rsp_q.out_0 <= fin[0];
			rsp_q.out_1 <= fin[1];
			rsp_q.out_2 <= fin[2];
			rsp_q.out_3 <= fin[3];
			rsp_q.out_4 <= fin[4];
			rsp_q.out_5 <= fin[5];
			rsp_q.out_6 <= fin[6];
			rsp_q.out_7 <= fin[7];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> chain[1].valid)
		else $error("accepted item did not enter the first cell");

	a_leave: assert property (@(posedge clk) disable iff (!arst_n)
		chain[N].valid && en |=> rsp_valid)
		else $error("item left the last cell but no result shown");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(chain[N].valid) && $stable(chain[1].valid) && $stable(rsp_q))
		else $error("chain moved while stalled");
`endif

endmodule

### tb/tb_gf16_matrix_round_layer.sv
// Self-checking testbench for the GF(2^16) matrix round layer with random handshake stalls.
`timescale 1ns / 1ps

module tb_gf16_matrix_round_layer;

	localparam int RANDOM_ITEMS = 700;
	localparam int DRAIN_AT     = 350;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 100;
	localparam int TAIL_CYCLES  = 16;

	localparam gf16mr_pkg::word_t GF_POLY_LOW = 16'h002B;

	typedef gf16mr_pkg::word_t [0:7] words8_t;
	typedef logic [0:7][0:7][15:0] coef_tab_t;

	typedef struct {
		gf16mr_pkg::req_t req;
		bit               drain;
	} stim_t;

	localparam coef_tab_t FWD_COEF = {
		16'h1967, 16'h2BA9, 16'h659C, 16'h7CFB, 16'h5752, 16'hCB38, 16'hE091, 16'h4E35,
		16'hB1C3, 16'h6F41, 16'hD26E, 16'hBD2F, 16'h7A75, 16'h63AD, 16'h0CEC, 16'hCBB6,
		16'h64CE, 16'hFDE8, 16'h9926, 16'hAB41, 16'h62DD, 16'hCF8F, 16'h56A9, 16'hC99C,
		16'h40E8, 16'h00D7, 16'hC041, 16'h403F, 16'hC096, 16'hC1EF, 16'h01AE, 16'h80A9,
		16'hAC87, 16'h91DF, 16'h4789, 16'h1EAC, 16'hB22B, 16'hD656, 16'hC8FA, 16'h7AD1,
		16'hC9BC, 16'h56B1, 16'hCF93, 16'h62F1, 16'hAB4D, 16'h9922, 16'hFDFC, 16'h64DE,
		16'h1472, 16'h7D59, 16'hB480, 16'h4E32, 16'h2719, 16'hEEC0, 16'hC9D9, 16'h5A40,
		16'hD081, 16'h271E, 16'h5AF3, 16'hFBDA, 16'h8637, 16'hAD6C, 16'h7DED, 16'h2B5B
	};

	localparam coef_tab_t INV_COEF = {
		16'h8644, 16'h738D, 16'h42A7, 16'h86B1, 16'h9477, 16'h07D8, 16'h9B6A, 16'hB308,
		16'h8AE7, 16'hD162, 16'h1204, 16'h077A, 16'h3086, 16'h021A, 16'hF967, 16'h19FC,
		16'h1946, 16'h9497, 16'h50A3, 16'h8276, 16'hFAA8, 16'h02E1, 16'hB113, 16'h3341,
		16'h9F02, 16'h45F5, 16'hF1E5, 16'h81CB, 16'hD26D, 16'h06D5, 16'h43F6, 16'h557A,
		16'h15E5, 16'h8BEA, 16'h74AB, 16'h850C, 16'h461A, 16'h010D, 16'h21FB, 16'h7FC7,
		16'h328C, 16'hE71A, 16'hB342, 16'h8C82, 16'hCA2E, 16'h00FB, 16'h698F, 16'h99B5,
		16'hB86B, 16'h3678, 16'hE3E1, 16'h0EF4, 16'h1843, 16'h0317, 16'h4874, 16'h2ABD,
		16'h93A1, 16'hF867, 16'h854E, 16'h04C7, 16'h5E59, 16'h03EC, 16'hD89C, 16'hE672
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	gf16mr_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	gf16mr_pkg::rsp_t rsp;

	stim_t            pending_q[$];
	gf16mr_pkg::rsp_t expected_q[$];
	stim_t            next_item;
	stim_t            build_item;
	words8_t          build_words;
	words8_t          got_words;
	words8_t          exp_words;
	gf16mr_pkg::rsp_t exp_rsp;

	int unsigned total_items = 0;
	int unsigned sent_cnt = 0;
	int unsigned got_cnt = 0;
	int unsigned fwd_cnt = 0;
	int unsigned inv_cnt = 0;
	int unsigned err_cnt = 0;
	int unsigned tx_gap = 0;
	int unsigned tx_burst = 0;
	int unsigned rx_stall = 0;
	int unsigned rx_burst = 0;
	bit          hold_done = 1'b0;

	gf16_matrix_round_layer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #4 clk = ~clk;

	// shift-and-add product, reduced by x^16 + x^5 + x^3 + x + 1
	function automatic gf16mr_pkg::word_t gf_mul(gf16mr_pkg::word_t a, gf16mr_pkg::word_t b);
		gf16mr_pkg::word_t acc;
		gf16mr_pkg::word_t m;
		acc = '0;
		m = a;
		for (int i = 0; i < 16; i++) begin
			if (b[i])
				acc ^= m;
			m = m[15] ? ((m << 1) ^ GF_POLY_LOW) : (m << 1);
		end
		return acc;
	endfunction

	function automatic gf16mr_pkg::rsp_t predict_layer(gf16mr_pkg::req_t r);
		words8_t x;
		words8_t y;
		x = {r.word_0, r.word_1, r.word_2, r.word_3, r.word_4, r.word_5, r.word_6, r.word_7};
		if (r.kind == gf16mr_pkg::KIND_INV)
			for (int s = 0; s < 8; s++)
				x[s] ^= gf16mr_pkg::word_t'(8 * r.round_index + s + 1);
		for (int s = 0; s < 8; s++) begin
			y[s] = '0;
			for (int b = 0; b < 8; b++)
				y[s] ^= gf_mul((r.kind == gf16mr_pkg::KIND_FWD) ?
					FWD_COEF[s][b] : INV_COEF[s][b], x[b]);
			if (r.kind == gf16mr_pkg::KIND_FWD)
				y[s] ^= gf16mr_pkg::word_t'(8 * r.round_index + s + 1);
		end
		return gf16mr_pkg::rsp_t'(y);
	endfunction

	// mostly a random idle gap, now and then a stretch with none
	function automatic int unsigned draw_idle(inout int unsigned burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 40);
			return 0;
		end
		return $urandom_range(0, 8);
	endfunction

	function automatic gf16mr_pkg::word_t rand_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return gf16mr_pkg::word_t'(1) << $urandom_range(0, 15);
			default: return gf16mr_pkg::word_t'($urandom);
		endcase
	endfunction

	// driver: expectation is recorded at the accepting edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (req_valid && req_ready) begin
				expected_q.push_back(predict_layer(req));
				if (req.kind == gf16mr_pkg::KIND_FWD)
					fwd_cnt++;
				else
					inv_cnt++;
				sent_cnt++;
			end
			if (!req_valid || req_ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (pending_q.size() > 0 &&
						!(pending_q[0].drain && sent_cnt != got_cnt)) begin
					next_item = pending_q.pop_front();
					req <= next_item.req;
					req_valid <= 1'b1;
					tx_gap = draw_idle(tx_burst);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result item: %h", rsp);
					err_cnt++;
				end else begin
					exp_rsp = expected_q.pop_front();
					exp_words = words8_t'(exp_rsp);
					got_words = words8_t'(rsp);
					for (int s = 0; s < 8; s++)
						if (got_words[s] !== exp_words[s]) begin
							$error("out_%0d: expected %h, actual %h", s, exp_words[s],
								got_words[s]);
							err_cnt++;
						end
				end
				got_cnt <= got_cnt + 1;
				rx_stall = draw_idle(rx_burst);
				// long hold-off so the chain fills and input backs up
				if (got_cnt == HOLD_AT && !hold_done) begin
					rx_stall = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		// zero and all-ones blocks, the latter with the highest round 7, then alternating-bit blocks
		build_item.drain = 1'b0;
		build_words = '0;
		build_item.req = {gf16mr_pkg::KIND_FWD, gf16mr_pkg::rnd_t'(0), build_words};
		pending_q.push_back(build_item);
		build_item.req = {gf16mr_pkg::KIND_INV, gf16mr_pkg::rnd_t'(0), build_words};
		pending_q.push_back(build_item);
		build_words = '1;
		build_item.req = {gf16mr_pkg::KIND_FWD, gf16mr_pkg::rnd_t'(7), build_words};
		pending_q.push_back(build_item);
		build_item.req = {gf16mr_pkg::KIND_INV, gf16mr_pkg::rnd_t'(7), build_words};
		pending_q.push_back(build_item);
		build_words = {4{16'h5555, 16'hAAAA}};
		build_item.req = {gf16mr_pkg::KIND_FWD, gf16mr_pkg::rnd_t'(3), build_words};
		pending_q.push_back(build_item);
		build_item.req = {gf16mr_pkg::KIND_INV, gf16mr_pkg::rnd_t'(6), build_words};
		pending_q.push_back(build_item);
		// every round index, single-bit words that hit the reduction
		for (int r = 0; r < 8; r++) begin
			for (int s = 0; s < 8; s++)
				build_words[s] = 16'h8000 >> ((s + 2 * r) % 16);
			build_item.req = {gf16mr_pkg::KIND_FWD, gf16mr_pkg::rnd_t'(r), build_words};
			pending_q.push_back(build_item);
			build_item.req = {gf16mr_pkg::KIND_INV, gf16mr_pkg::rnd_t'(r), build_words};
			pending_q.push_back(build_item);
		end
		for (int j = 0; j < RANDOM_ITEMS; j++) begin
			for (int s = 0; s < 8; s++)
				build_words[s] = rand_word();
			build_item.req = {gf16mr_pkg::kind_t'($urandom_range(0, 1)),
				gf16mr_pkg::rnd_t'($urandom_range(0, 7)), build_words};
			build_item.drain = (j == DRAIN_AT);
			pending_q.push_back(build_item);
		end
		total_items = pending_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (sent_cnt == total_items && got_cnt == total_items);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Checked %0d items (%0d forward, %0d inverse), rounds 0..7, with stalls on both",
			got_cnt, fwd_cnt, inv_cnt);
		$display("sides, one long output hold-off and one full drain; %0d mismatches.", err_cnt);
		if (err_cnt == 0 && expected_q.size() == 0 && got_cnt == sent_cnt)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
